FILE: rtl/core/ued_pkg.sv
`timescale 1ns / 1ps

package ued_pkg;

	// Character codes of the escape form
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_U      = 8'h75;
	localparam logic [7:0] CHAR_0      = 8'h30;
	localparam logic [7:0] CHAR_9      = 8'h39;
	localparam logic [7:0] CHAR_UC_A   = 8'h41;
	localparam logic [7:0] CHAR_UC_F   = 8'h46;
	localparam logic [7:0] CHAR_LC_A   = 8'h61;
	localparam logic [7:0] CHAR_LC_F   = 8'h66;

	// Codepoint constants
	localparam logic [15:0] SURR_LO   = 16'hD800;
	localparam logic [15:0] SURR_HI   = 16'hDFFF;
	localparam logic [31:0] PLANE_ONE = 32'h0001_0000;
	localparam logic [31:0] NO_RESULT = 32'hFFFF_FFFF;

	// Request: two six-byte escape slots
	typedef struct packed {
		logic [47:0] escape_first;
		logic [47:0] escape_second;
	} ued_req_t;

	// Response: two codepoint lanes
	typedef struct packed {
		logic [31:0] first_codepoint;
		logic [31:0] second_codepoint;
	} ued_rsp_t;

	// Classified item passed from front to back
	typedef struct packed {
		logic [15:0] value_first;
		logic [15:0] value_second;
		logic        both_ok;
		logic        surr_first;
		logic        surr_second;
	} ued_cls_t;

endpackage

FILE: rtl/core/ued_front.sv
`timescale 1ns / 1ps

module ued_front (
	input  logic              req_valid,
	output logic              req_stall,
	input  ued_pkg::ued_req_t req,
	output logic              push,
	output ued_pkg::ued_cls_t cls,
	input  logic              queue_full
);
	import ued_pkg::*;

	// {ok, nibble} for one digit character; non-hex counts as zero
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= CHAR_UC_A && c <= CHAR_UC_F) ||
			     (c >= CHAR_LC_A && c <= CHAR_LC_F)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Slot check and value; bit 16 is the valid flag
	function automatic logic [16:0] decode_slot(input logic [47:0] s);
		logic [4:0] d2, d3, d4, d5;
		logic       ok;
		d2 = hex_nib(s[23:16]);
		d3 = hex_nib(s[31:24]);
		d4 = hex_nib(s[39:32]);
		d5 = hex_nib(s[47:40]);
		ok = (s[7:0] == CHAR_BSLASH) && (s[15:8] == CHAR_U) &&
		     d2[4] && d3[4] && d4[4] && d5[4];
		return {ok, d2[3:0], d3[3:0], d4[3:0], d5[3:0]};
	endfunction

	logic [16:0] slot_a;
	logic [16:0] slot_b;

	// Classify the window
	always_comb begin
		slot_a          = decode_slot(req.escape_first);
		slot_b          = decode_slot(req.escape_second);
		cls.value_first  = slot_a[15:0];
		cls.value_second = slot_b[15:0];
		cls.both_ok      = slot_a[16] & slot_b[16];
		cls.surr_first   = (slot_a[15:0] >= SURR_LO) && (slot_a[15:0] <= SURR_HI);
		cls.surr_second  = (slot_b[15:0] >= SURR_LO) && (slot_b[15:0] <= SURR_HI);
	end

	// Accept whenever the queue has room
	assign req_stall = queue_full;
	assign push      = req_valid & ~queue_full;

endmodule

FILE: rtl/core/ued_queue.sv
`timescale 1ns / 1ps

module ued_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ued_pkg::ued_cls_t push_data,
	output logic              full,
	output logic              head_valid,
	input  logic              pop,
	output ued_pkg::ued_cls_t head
);
	import ued_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ued_cls_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	// Storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

endmodule

FILE: rtl/core/ued_back.sv
`timescale 1ns / 1ps

module ued_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  ued_pkg::ued_cls_t head,
	output logic              pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ued_pkg::ued_rsp_t rsp
);
	import ued_pkg::*;

	ued_rsp_t result;
	logic     out_valid_q;
	ued_rsp_t out_q;

	// Pair combine or pass-through per lane
	always_comb begin
		if (!head.surr_first) begin
			result.first_codepoint = {16'd0, head.value_first};
		end else if (head.both_ok && head.surr_second) begin
			result.first_codepoint = PLANE_ONE +
				{12'd0, head.value_first[9:0], head.value_second[9:0]};
		end else begin
			result.first_codepoint = NO_RESULT;
		end
		result.second_codepoint = (head.both_ok && !head.surr_second) ?
			{16'd0, head.value_second} : NO_RESULT;
	end

	// Take the head when the output register is free or draining
	assign pop = head_valid & (~out_valid_q | ~rsp_stall);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !rsp_stall) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= result;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: rtl/core/unicode_escape_pair_decoder_top.sv
`timescale 1ns / 1ps
// Decoder for a pair of \uXXXX escapes taken from a text stream.
// Request channel (req_valid / req_stall / req): one twelve-byte window per
// transfer, split into escape_first and escape_second, first byte in bits 7:0.
// Response channel (rsp_valid / rsp_stall / rsp): one result per request,
// in order: first_codepoint holds the lone or paired codepoint, and
// second_codepoint the unpaired second value; all ones marks an empty lane.
// Throughput: one window per cycle while rsp_stall stays low. The front end
// classifies the window in the cycle it is taken and writes it to a
// QUEUE_DEPTH entry queue; the back end forms the codepoints and loads the
// output register. A result passes through the queue and the output
// register before it shows on rsp, and transfers when rsp_stall is low.
// When rsp_stall holds, the output register keeps its result, the queue
// fills, and req_stall rises once QUEUE_DEPTH items wait behind the output.
// Reset clears the queue and the output valid; no request is lost across
// a stall, and the block takes requests right after reset.
module unicode_escape_pair_decoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ued_pkg::ued_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ued_pkg::ued_rsp_t rsp
);
	import ued_pkg::*;

	logic     push;
	logic     queue_full;
	ued_cls_t cls;
	logic     head_valid;
	logic     pop;
	ued_cls_t head;

	ued_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.push       (push),
		.cls        (cls),
		.queue_full (queue_full)
	);

	ued_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (cls),
		.full       (queue_full),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	ued_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

FILE: rtl/core/ued_checker.sv
`timescale 1ns / 1ps

module ued_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input ued_pkg::ued_rsp_t rsp
);
	import ued_pkg::*;

	// A stalled response keeps its valid and payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// First lane: BMP non-surrogate, supplementary plane value, or empty
	a_first_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			(rsp.first_codepoint <= 32'h0000_FFFF &&
			 !(rsp.first_codepoint >= 32'h0000_D800 &&
			   rsp.first_codepoint <= 32'h0000_DFFF)) ||
			(rsp.first_codepoint >= PLANE_ONE &&
			 rsp.first_codepoint <= 32'h0010_FFFF) ||
			(rsp.first_codepoint == NO_RESULT))
		else $error("first codepoint out of range");

	// Second lane: BMP non-surrogate or empty
	a_second_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			(rsp.second_codepoint <= 32'h0000_FFFF &&
			 !(rsp.second_codepoint >= 32'h0000_D800 &&
			   rsp.second_codepoint <= 32'h0000_DFFF)) ||
			(rsp.second_codepoint == NO_RESULT))
		else $error("second codepoint out of range");

	// A filled second lane means no pair was formed
	a_no_pair_with_second: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.second_codepoint != NO_RESULT |->
			rsp.first_codepoint <= 32'h0000_FFFF ||
			rsp.first_codepoint == NO_RESULT)
		else $error("pair and second codepoint both reported");

endmodule

bind unicode_escape_pair_decoder_top ued_checker u_ued_checker (.*);

FILE: tb/tb_unicode_escape_pair_decoder_top.sv
`timescale 1ns / 1ps

module tb_unicode_escape_pair_decoder_top;

	import ued_pkg::*;

	localparam int RANDOM_WINDOWS = 1530;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int REPORT_LIMIT   = 10;

	// Receiver stall behavior, rotated by bits 9:8 of stall_cycle
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	// One row of the directed table
	typedef struct {
		ued_req_t window;
		bit       typed;
		ued_rsp_t want;
	} dir_row_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	ued_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	ued_rsp_t rsp;

	ued_rsp_t    expected_codepoints[$];
	dir_row_t    dir_rows[$];
	int          burst_left;
	int          windows_sent;
	int          results_checked;
	int          pairs_combined;
	int          error_count;
	int          idle_cycles;
	logic [9:0]  stall_cycle;

	unicode_escape_pair_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// Value of one \uXXXX slot; well_formed is low on a bad prefix or a non-hex digit
	function automatic logic [15:0] slot_value(input logic [47:0] slot, output bit well_formed);
		logic [7:0]  ch;
		logic [15:0] acc;
		well_formed = (slot[7:0] == CHAR_BSLASH) && (slot[15:8] == CHAR_U);
		acc = '0;
		for (int i = 2; i < 6; i++) begin
			ch = slot[8*i +: 8];
			acc = acc << 4;
			if (ch >= CHAR_0 && ch <= CHAR_9) begin
				acc[3:0] = 4'(ch - CHAR_0);
			end else if (ch >= CHAR_UC_A && ch <= CHAR_UC_F) begin
				acc[3:0] = 4'(ch - CHAR_UC_A + 8'd10);
			end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_F) begin
				acc[3:0] = 4'(ch - CHAR_LC_A + 8'd10);
			end else begin
				well_formed = 1'b0;
			end
		end
		return acc;
	endfunction

	// Expected codepoints for one twelve-byte window
	function automatic ued_rsp_t decode_escape_pair(input ued_req_t w);
		ued_rsp_t    r;
		logic [15:0] val_a;
		logic [15:0] val_b;
		bit          ok_a;
		bit          ok_b;
		bit          sur_a;
		bit          sur_b;
		val_a = slot_value(w.escape_first, ok_a);
		val_b = slot_value(w.escape_second, ok_b);
		sur_a = (val_a >= SURR_LO) && (val_a <= SURR_HI);
		sur_b = (val_b >= SURR_LO) && (val_b <= SURR_HI);
		// any two surrogates combine, order is not checked
		if (!sur_a) begin
			r.first_codepoint = {16'h0, val_a};
		end else if (ok_a && ok_b && sur_b) begin
			r.first_codepoint = PLANE_ONE + {12'h0, val_a[9:0], 10'h0} + {22'h0, val_b[9:0]};
		end else begin
			r.first_codepoint = NO_RESULT;
		end
		r.second_codepoint = (ok_a && ok_b && !sur_b) ? {16'h0, val_b} : NO_RESULT;
		return r;
	endfunction

	// Six characters of text, first one in bits 7:0
	function automatic logic [47:0] text_slot(input string t);
		logic [47:0] s;
		s = '0;
		for (int i = 0; i < 6 && i < t.len(); i++)
			s[8*i +: 8] = t[i];
		return s;
	endfunction

	// Mostly well-formed escapes, biased toward surrogates, some corrupted or raw
	function automatic logic [47:0] random_escape();
		logic [47:0] s;
		logic [15:0] v;
		logic [3:0]  nib;
		int          pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			s[47:16] = $urandom;
			s[15:0]  = 16'($urandom);
			return s;
		end
		if (pick < 8)
			v = SURR_LO | 16'($urandom_range(0, 16'h07FF));
		else if (pick == 8)
			v = $urandom_range(0, 1) ? SURR_LO - 16'd1 : SURR_HI + 16'd1;
		else
			v = 16'($urandom);
		s[7:0]  = CHAR_BSLASH;
		s[15:8] = CHAR_U;
		for (int i = 0; i < 4; i++) begin
			nib = v[15 - 4*i -: 4];
			if (nib < 4'd10)
				s[8*(i+2) +: 8] = CHAR_0 + 8'(nib);
			else
				s[8*(i+2) +: 8] = ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + 8'(nib - 4'd10);
		end
		if ($urandom_range(0, 9) == 0)
			s[8*$urandom_range(0, 5) +: 8] = 8'($urandom);
		return s;
	endfunction

	task automatic add_row(input logic [47:0] first_slot, input logic [47:0] second_slot,
			input bit typed, input logic [31:0] want_first, input logic [31:0] want_second);
		dir_row_t row;
		row.window.escape_first   = first_slot;
		row.window.escape_second  = second_slot;
		row.typed                 = typed;
		row.want.first_codepoint  = want_first;
		row.want.second_codepoint = want_second;
		dir_rows.push_back(row);
	endtask

	// Drive one window in bursts with random gaps; the expectation is queued on transfer
	task automatic drive_window(input ued_req_t w, input ued_rsp_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
		expected_codepoints.push_back(want);
		windows_sent++;
	endtask

	// Receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall   <= 1'b0;
			stall_cycle <= '0;
		end else begin
			stall_cycle <= stall_cycle + 10'd1;
			case (stall_mode_t'(stall_cycle[9:8]))
				STALL_NONE: begin
					rsp_stall <= 1'b0;
				end
				STALL_SPARSE: begin
					rsp_stall <= ($urandom_range(0, 3) == 0);
				end
				STALL_PERIODIC: begin
					rsp_stall <= (stall_cycle[3:1] == 3'b111);
				end
				default: begin
					rsp_stall <= ($urandom_range(0, 3) != 0);
				end
			endcase
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin : rsp_check
		ued_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_codepoints.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("unexpected result: first %h second %h",
						rsp.first_codepoint, rsp.second_codepoint);
			end else begin
				want = expected_codepoints.pop_front();
				results_checked++;
				if (want.first_codepoint != NO_RESULT && want.first_codepoint >= PLANE_ONE)
					pairs_combined++;
				if (rsp.first_codepoint != want.first_codepoint ||
						rsp.second_codepoint != want.second_codepoint) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("result %0d: first exp %h got %h, second exp %h got %h",
							results_checked, want.first_codepoint, rsp.first_codepoint,
							want.second_codepoint, rsp.second_codepoint);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Stimulus
	initial begin
		ued_req_t w;

		// zero bytes and 0xFF bytes: non-hex digits give value 0, slots invalid
		add_row('0, '0, 1'b1, 32'h0, NO_RESULT);
		add_row('1, '1, 1'b1, 32'h0, NO_RESULT);
		add_row(text_slot("\\u0041"), text_slot("\\u0042"), 1'b1, 32'h41, 32'h42);
		add_row(text_slot("\\ud83d"), text_slot("\\ude00"), 1'b1, 32'h1F600, NO_RESULT);
		add_row(text_slot("\\uD83D"), text_slot("\\uDE00"), 1'b1, 32'h1F600, NO_RESULT);
		// low surrogate first still combines
		add_row(text_slot("\\uDE00"), text_slot("\\uD83D"), 1'b0, '0, '0);
		add_row(text_slot("\\uD800"), text_slot("\\uD800"), 1'b1, 32'h10000, NO_RESULT);
		add_row(text_slot("\\uDFFF"), text_slot("\\uDFFF"), 1'b1, 32'h10FFFF, NO_RESULT);
		add_row(text_slot("\\uD7FF"), text_slot("\\uE000"), 1'b1, 32'hD7FF, 32'hE000);
		add_row(text_slot("\\u0000"), text_slot("\\uFFFF"), 1'b1, 32'h0, 32'hFFFF);
		add_row(text_slot("\\uffff"), text_slot("\\uAbCd"), 1'b1, 32'hFFFF, 32'hABCD);
		// bad prefix on the first slot: value still reported
		add_row(text_slot("xu0041"), text_slot("\\u0042"), 1'b1, 32'h41, NO_RESULT);
		add_row(text_slot("\\x0041"), text_slot("\\u0042"), 1'b0, '0, '0);
		// non-hex digits count as zero
		add_row(text_slot("\\u00G1"), text_slot("\\u0042"), 1'b0, '0, '0);
		add_row(text_slot("\\u0041"), text_slot("\\u0g42"), 1'b0, '0, '0);
		add_row(text_slot("\\u/@Gg"), text_slot("\\u0000"), 1'b0, '0, '0);
		add_row(text_slot("\\u9:Fa"), text_slot("\\u1234"), 1'b0, '0, '0);
		add_row(text_slot("\\uD800"), text_slot("\\u0041"), 1'b1, NO_RESULT, 32'h41);
		add_row(text_slot("\\uD800"), text_slot("\\u00:1"), 1'b1, NO_RESULT, NO_RESULT);
		add_row(text_slot("/uDBFF"), text_slot("\\uDC00"), 1'b0, '0, '0);
		add_row(text_slot("\\u9AFa"), text_slot("\\uD800"), 1'b0, '0, '0);
		add_row(text_slot("\\uDBFF"), '0, 1'b0, '0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k])
			drive_window(dir_rows[k].window,
				dir_rows[k].typed ? dir_rows[k].want : decode_escape_pair(dir_rows[k].window));

		for (int n = 0; n < RANDOM_WINDOWS; n++) begin
			w.escape_first  = random_escape();
			w.escape_second = random_escape();
			drive_window(w, decode_escape_pair(w));
		end
		req_valid <= 1'b0;

		while (expected_codepoints.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d windows (%0d directed), %0d results compared, %0d pairs combined",
			windows_sent, dir_rows.size(), results_checked, pairs_combined);
		$display("Mismatches: %0d", error_count);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
